### rtl/core/fdmd_pkg.sv
// Shared types and constants of the frame difference motion detector.
package fdmd_pkg;

  // Field and counter widths.
  localparam int DIM_W      = 12;
  localparam int PIX_W      = 8;
  localparam int SQ_W       = 2 * PIX_W;
  localparam int ENERGY_W   = 48;
  localparam int RSUM_W     = 32;
  localparam int FLAGS_W    = 64;
  localparam int RCNT_W     = 7;
  localparam int RECT_NUM_W = RCNT_W + DIM_W;
  localparam int AREA_W     = 2 * DIM_W;

  // Rectangle counters stop at this value.
  localparam logic [RCNT_W-1:0] RCNT_MAX = 7'd127;

  // Energy history ring.
  localparam int HIST_DEPTH = 16;
  localparam int HIST_AW    = $clog2(HIST_DEPTH);
  localparam int HIST_SUM_W = ENERGY_W + HIST_AW;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RECT_WIDTH   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RECT_HEIGHT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DIFF_FLOOR   = 3'd4;

  // Register values after reset.
  localparam logic [DIM_W-1:0] IMAGE_WIDTH_RST  = 12'd640;
  localparam logic [DIM_W-1:0] IMAGE_HEIGHT_RST = 12'd480;
  localparam logic [DIM_W-1:0] RECT_WIDTH_RST   = 12'd80;
  localparam logic [DIM_W-1:0] RECT_HEIGHT_RST  = 12'd60;
  localparam logic [PIX_W-1:0] DIFF_FLOOR_RST   = 8'd40;

  // Control sequence of the top level.
  typedef enum logic [3:0] {
    ST_DIV,
    ST_PREP_MUL,
    ST_PREP_SET,
    ST_RUN,
    ST_WAIT,
    ST_MIN,
    ST_FLAG,
    ST_HIST,
    ST_EMIT
  } state_t;

  // Position of the current pixel as seen by the raster counters.
  typedef struct packed {
    logic                  frame_end;
    logic                  in_grid;
    logic [RECT_NUM_W-1:0] rect_num;
  } raster_pos_t;

endpackage

### rtl/core/fdmd_ram.sv
// Generic single-port-write, registered-read memory.
module fdmd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                         clk,
  input  logic                                         wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                             wr_data,
  input  logic                                         rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                             rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### rtl/core/fdmd_div.sv
// Restoring divider for image dimensions, one quotient bit per cycle.
module fdmd_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [fdmd_pkg::DIM_W-1:0] dividend,
  input  logic [fdmd_pkg::DIM_W-1:0] divisor,
  output logic                       busy,
  output logic [fdmd_pkg::DIM_W-1:0] quotient
);

  localparam int CNT_W = $clog2(fdmd_pkg::DIM_W + 1);

  logic [fdmd_pkg::DIM_W-1:0] rem;
  logic [fdmd_pkg::DIM_W-1:0] quo;
  logic [CNT_W-1:0]           count;
  logic [fdmd_pkg::DIM_W:0]   trial;
  logic                       fits;

  // Shift in the next dividend bit and try to subtract the divisor.
  assign trial    = {rem, quo[fdmd_pkg::DIM_W-1]};
  assign fits     = trial >= {1'b0, divisor};
  assign quotient = quo;

  // Control: busy until every quotient bit has been produced.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      count <= CNT_W'(fdmd_pkg::DIM_W);
    end else if (busy) begin
      count <= count - CNT_W'(1);
      if (count == CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  // Datapath: partial remainder and quotient shift register.
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
    end else if (busy) begin
      rem <= fits ? fdmd_pkg::DIM_W'(trial - {1'b0, divisor}) : trial[fdmd_pkg::DIM_W-1:0];
      quo <= {quo[fdmd_pkg::DIM_W-2:0], fits};
    end
  end

endmodule

### rtl/core/fdmd_raster.sv
// Raster position counters: pixel, row and motion rectangle coordinates.
module fdmd_raster (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       step,
  input  logic [fdmd_pkg::DIM_W-1:0] img_w,
  input  logic [fdmd_pkg::DIM_W-1:0] img_h,
  input  logic [fdmd_pkg::DIM_W-1:0] rect_w,
  input  logic [fdmd_pkg::DIM_W-1:0] rect_h,
  input  logic [fdmd_pkg::DIM_W-1:0] across,
  input  logic [fdmd_pkg::DIM_W-1:0] down,
  output fdmd_pkg::raster_pos_t      pos
);

  logic [fdmd_pkg::DIM_W-1:0]      pixel_column;
  logic [fdmd_pkg::DIM_W-1:0]      pixel_row;
  logic [fdmd_pkg::DIM_W-1:0]      column_in_rect;
  logic [fdmd_pkg::DIM_W-1:0]      row_in_rect;
  logic [fdmd_pkg::RCNT_W-1:0]     rect_column;
  logic [fdmd_pkg::RCNT_W-1:0]     rect_row;
  logic                            row_end;
  logic                            col_wrap;
  logic                            row_wrap;
  logic [fdmd_pkg::RECT_NUM_W-1:0] row_base;

  // End of row, end of frame and end of rectangle decisions.
  assign row_end  = ({1'b0, pixel_column} + 13'd1) >= {1'b0, img_w};
  assign col_wrap = ({1'b0, column_in_rect} + 13'd1) >= {1'b0, rect_w};
  assign row_wrap = ({1'b0, row_in_rect} + 13'd1) >= {1'b0, rect_h};

  // Rectangle number, counted row by row.
  assign row_base = fdmd_pkg::RECT_NUM_W'({{fdmd_pkg::DIM_W{1'b0}}, rect_row}
                    * {{fdmd_pkg::RCNT_W{1'b0}}, across});

  always_comb begin
    pos.frame_end = row_end && (({1'b0, pixel_row} + 13'd1) >= {1'b0, img_h});
    pos.in_grid   = ({5'b0, rect_column} < across) && ({5'b0, rect_row} < down);
    pos.rect_num  = row_base + fdmd_pkg::RECT_NUM_W'(rect_column);
  end

  // Counter updates on every accepted pixel.
  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_column   <= '0;
      pixel_row      <= '0;
      column_in_rect <= '0;
      row_in_rect    <= '0;
      rect_column    <= '0;
      rect_row       <= '0;
    end else if (step) begin
      if (pos.frame_end) begin
        pixel_column   <= '0;
        pixel_row      <= '0;
        column_in_rect <= '0;
        row_in_rect    <= '0;
        rect_column    <= '0;
        rect_row       <= '0;
      end else if (row_end) begin
        pixel_column   <= '0;
        column_in_rect <= '0;
        rect_column    <= '0;
        pixel_row      <= pixel_row + fdmd_pkg::DIM_W'(1);
        if (row_wrap) begin
          row_in_rect <= '0;
          if (rect_row < fdmd_pkg::RCNT_MAX) begin
            rect_row <= rect_row + fdmd_pkg::RCNT_W'(1);
          end
        end else begin
          row_in_rect <= row_in_rect + fdmd_pkg::DIM_W'(1);
        end
      end else begin
        pixel_column <= pixel_column + fdmd_pkg::DIM_W'(1);
        if (col_wrap) begin
          column_in_rect <= '0;
          if (rect_column < fdmd_pkg::RCNT_MAX) begin
            rect_column <= rect_column + fdmd_pkg::RCNT_W'(1);
          end
        end else begin
          column_in_rect <= column_in_rect + fdmd_pkg::DIM_W'(1);
        end
      end
    end
  end

endmodule

### rtl/core/frame_difference_motion_detector_unit.sv
// Top level of the frame difference motion detector.
//
// Pixels arrive in raster order on the input channel (in_valid, in_stall,
// cur_pixel, base_pixel); one transfer is one pixel. Every pixel gives one
// transfer on the output channel (out_valid, out_stall and the result
// fields). A pixel's result passes through the update stage and then
// the output register. Within a frame the block takes one pixel per cycle
// while the output side keeps up; the rectangle sums live in a memory
// with one read port, updated by read-modify-write with forwarding.
// After the last pixel of a frame the input is held while the rectangle
// memory is read twice over the R whole rectangles (at most MAX_RECTS),
// once for the minimum and once for the flags, and the energy history
// memory gives the oldest energy. After reset and after every
// configuration write the block derives the rectangle grid (two 12-bit
// serial dividers) and holds in_stall high meanwhile. Reset restores the
// register defaults and clears all sums and the history. A stalled output
// keeps its result, and the input side stalls once the one internal stage
// behind it is full.
module frame_difference_motion_detector_unit #(
  parameter int MAX_RECTS = 64
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [fdmd_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [fdmd_pkg::DIM_W-1:0]           cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [fdmd_pkg::PIX_W-1:0]           cur_pixel,
  input  logic [fdmd_pkg::PIX_W-1:0]           base_pixel,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [fdmd_pkg::PIX_W-1:0]           diff_pixel,
  output logic                                 frame_done,
  output logic [fdmd_pkg::ENERGY_W-1:0]        frame_energy,
  output logic                                 motion_flag,
  output logic [fdmd_pkg::ENERGY_W-1:0]        energy_average,
  output logic [fdmd_pkg::FLAGS_W-1:0]         rect_flags
);

  localparam int RECT_AW = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;
  localparam int TOT_W   = RECT_AW + 1;

  // Configuration registers.
  logic [fdmd_pkg::DIM_W-1:0] image_width;
  logic [fdmd_pkg::DIM_W-1:0] image_height;
  logic [fdmd_pkg::DIM_W-1:0] rect_width;
  logic [fdmd_pkg::DIM_W-1:0] rect_height;
  logic [fdmd_pkg::PIX_W-1:0] diff_floor;
  logic [fdmd_pkg::DIM_W-1:0] iw_eff;
  logic [fdmd_pkg::DIM_W-1:0] ih_eff;
  logic [fdmd_pkg::DIM_W-1:0] rw_eff;
  logic [fdmd_pkg::DIM_W-1:0] rh_eff;

  // Control.
  fdmd_pkg::state_t state;
  fdmd_pkg::state_t state_next;
  logic             div_go;
  logic             div_start;
  logic             busy_across;
  logic             busy_down;
  logic             scan_active;
  logic             hist_step;
  logic             emit_fire;
  logic             out_free;
  logic             accept;

  // Grid geometry.
  logic [fdmd_pkg::DIM_W-1:0]  across;
  logic [fdmd_pkg::DIM_W-1:0]  down;
  logic [fdmd_pkg::AREA_W-1:0] rect_area;
  logic [fdmd_pkg::AREA_W-1:0] grid_count;
  logic [fdmd_pkg::RSUM_W-1:0] min_init;
  logic [TOT_W-1:0]            total;

  // Input stage.
  fdmd_pkg::raster_pos_t          pos;
  logic [fdmd_pkg::PIX_W-1:0]     diff_a;
  logic [fdmd_pkg::SQ_W-1:0]      diff_sq;
  logic [fdmd_pkg::ENERGY_W-1:0]  acc_next;
  logic [fdmd_pkg::ENERGY_W-1:0]  energy_accumulator;
  logic                           a_in_rect;
  logic [RECT_AW-1:0]             a_addr;

  // Update stage of the rectangle sum memory.
  logic                        b_valid;
  logic                        b_end;
  logic                        b_in_rect;
  logic                        b_hit;
  logic [RECT_AW-1:0]          b_addr;
  logic [fdmd_pkg::PIX_W-1:0]  b_diff;
  logic                        b_fire;
  logic [fdmd_pkg::RSUM_W-1:0] fwd_data;
  logic [fdmd_pkg::RSUM_W-1:0] b_oper;
  logic [fdmd_pkg::RSUM_W-1:0] b_sum;
  logic                        rect_wr_en;
  logic                        rect_rd_en;
  logic [RECT_AW-1:0]          rect_rd_addr;
  logic [fdmd_pkg::RSUM_W-1:0] rect_rd_data;
  logic [MAX_RECTS-1:0]        rect_valid;

  // Frame end scan.
  logic [TOT_W-1:0]             scan_cnt;
  logic                         scan_issue;
  logic                         pipe_valid;
  logic [RECT_AW-1:0]           pipe_idx;
  logic [fdmd_pkg::RSUM_W-1:0]  scan_data;
  logic [fdmd_pkg::RSUM_W-1:0]  min_val;
  logic [fdmd_pkg::FLAGS_W-1:0] flags_acc;

  // Frame summary and energy history.
  logic [fdmd_pkg::PIX_W-1:0]      end_diff;
  logic [fdmd_pkg::ENERGY_W-1:0]   energy_hold;
  logic                            motion_hold;
  logic [fdmd_pkg::ENERGY_W-1:0]   prior_average;
  logic [fdmd_pkg::HIST_SUM_W-1:0] sum_run;
  logic [fdmd_pkg::HIST_SUM_W-1:0] sum_next;
  logic [fdmd_pkg::HIST_AW-1:0]    history_slot;
  logic [fdmd_pkg::HIST_DEPTH-1:0] hist_valid;
  logic [fdmd_pkg::ENERGY_W-1:0]   hist_rd_data;
  logic [fdmd_pkg::ENERGY_W-1:0]   hist_old;

  // A dimension register holding zero acts as one.
  assign iw_eff = (image_width == '0) ? fdmd_pkg::DIM_W'(1) : image_width;
  assign ih_eff = (image_height == '0) ? fdmd_pkg::DIM_W'(1) : image_height;
  assign rw_eff = (rect_width == '0) ? fdmd_pkg::DIM_W'(1) : rect_width;
  assign rh_eff = (rect_height == '0) ? fdmd_pkg::DIM_W'(1) : rect_height;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= fdmd_pkg::IMAGE_WIDTH_RST;
      image_height <= fdmd_pkg::IMAGE_HEIGHT_RST;
      rect_width   <= fdmd_pkg::RECT_WIDTH_RST;
      rect_height  <= fdmd_pkg::RECT_HEIGHT_RST;
      diff_floor   <= fdmd_pkg::DIFF_FLOOR_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        fdmd_pkg::REG_IMAGE_WIDTH:  image_width  <= cfg_data;
        fdmd_pkg::REG_IMAGE_HEIGHT: image_height <= cfg_data;
        fdmd_pkg::REG_RECT_WIDTH:   rect_width   <= cfg_data;
        fdmd_pkg::REG_RECT_HEIGHT:  rect_height  <= cfg_data;
        fdmd_pkg::REG_DIFF_FLOOR:   diff_floor   <= cfg_data[fdmd_pkg::PIX_W-1:0];
        default: ;
      endcase
    end
  end

  // State register and divider launch request.
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= fdmd_pkg::ST_DIV;
      div_go <= 1'b1;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        div_go <= 1'b1;
      end else if (div_start) begin
        div_go <= 1'b0;
      end
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      fdmd_pkg::ST_DIV: begin
        if (!div_go && !busy_across && !busy_down) state_next = fdmd_pkg::ST_PREP_MUL;
      end
      fdmd_pkg::ST_PREP_MUL: state_next = fdmd_pkg::ST_PREP_SET;
      fdmd_pkg::ST_PREP_SET: state_next = fdmd_pkg::ST_RUN;
      fdmd_pkg::ST_RUN: begin
        if (accept && pos.frame_end) state_next = fdmd_pkg::ST_WAIT;
      end
      fdmd_pkg::ST_WAIT: state_next = fdmd_pkg::ST_MIN;
      fdmd_pkg::ST_MIN: begin
        if (!scan_issue && !pipe_valid) state_next = fdmd_pkg::ST_FLAG;
      end
      fdmd_pkg::ST_FLAG: begin
        if (!scan_issue && !pipe_valid) state_next = fdmd_pkg::ST_HIST;
      end
      fdmd_pkg::ST_HIST: state_next = fdmd_pkg::ST_EMIT;
      fdmd_pkg::ST_EMIT: begin
        if (out_free) state_next = fdmd_pkg::ST_RUN;
      end
      default: state_next = fdmd_pkg::ST_DIV;
    endcase
    if (cfg_we) begin
      state_next = fdmd_pkg::ST_DIV;
    end
  end

  // Handshake and sequencing controls.
  assign out_free = !out_valid || !out_stall;
  assign b_fire   = b_valid && (b_end || out_free);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    in_stall    = (state != fdmd_pkg::ST_RUN) || (b_valid && !b_fire);
    div_start   = (state == fdmd_pkg::ST_DIV) && div_go;
    scan_active = (state == fdmd_pkg::ST_MIN) || (state == fdmd_pkg::ST_FLAG);
    hist_step   = (state == fdmd_pkg::ST_HIST);
    emit_fire   = (state == fdmd_pkg::ST_EMIT) && out_free;
  end

  // Rectangles across and down the image.
  fdmd_div u_div_across (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (iw_eff),
    .divisor  (rw_eff),
    .busy     (busy_across),
    .quotient (across)
  );

  fdmd_div u_div_down (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (ih_eff),
    .divisor  (rh_eff),
    .busy     (busy_down),
    .quotient (down)
  );

  // Rectangle count and the starting minimum (255 times the rectangle area).
  always_ff @(posedge clk) begin
    if (state == fdmd_pkg::ST_PREP_MUL) begin
      rect_area  <= {{fdmd_pkg::DIM_W{1'b0}}, rw_eff} * {{fdmd_pkg::DIM_W{1'b0}}, rh_eff};
      grid_count <= {{fdmd_pkg::DIM_W{1'b0}}, across} * {{fdmd_pkg::DIM_W{1'b0}}, down};
    end
    if (state == fdmd_pkg::ST_PREP_SET) begin
      min_init <= {rect_area, 8'b0} - fdmd_pkg::RSUM_W'(rect_area);
      total    <= (grid_count > fdmd_pkg::AREA_W'(MAX_RECTS))
                  ? TOT_W'(MAX_RECTS) : grid_count[TOT_W-1:0];
    end
  end

  // Raster counters.
  fdmd_raster u_raster (
    .clk    (clk),
    .rst    (rst),
    .step   (accept),
    .img_w  (iw_eff),
    .img_h  (ih_eff),
    .rect_w (rw_eff),
    .rect_h (rh_eff),
    .across (across),
    .down   (down),
    .pos    (pos)
  );

  // Difference, energy term and rectangle address of the incoming pixel.
  assign diff_a    = (cur_pixel > base_pixel) ? cur_pixel - base_pixel : '0;
  assign diff_sq   = {8'b0, diff_a} * {8'b0, diff_a};
  assign acc_next  = energy_accumulator
                     + ((diff_a > diff_floor) ? fdmd_pkg::ENERGY_W'(diff_sq) : '0);
  assign a_in_rect = pos.in_grid && (pos.rect_num < fdmd_pkg::RECT_NUM_W'(MAX_RECTS));
  assign a_addr    = pos.rect_num[RECT_AW-1:0];

  // Frame energy accumulator.
  always_ff @(posedge clk) begin
    if (rst) begin
      energy_accumulator <= '0;
    end else if (accept) begin
      energy_accumulator <= pos.frame_end ? '0 : acc_next;
    end
  end

  // Values kept for the frame summary.
  always_ff @(posedge clk) begin
    if (accept && pos.frame_end) begin
      energy_hold <= acc_next;
      end_diff    <= diff_a;
    end
  end

  // Update stage: holds one pixel while its rectangle sum is read.
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (accept) begin
      b_valid <= 1'b1;
    end else if (b_fire) begin
      b_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      b_end     <= pos.frame_end;
      b_in_rect <= a_in_rect;
      b_addr    <= a_addr;
      b_diff    <= diff_a;
      b_hit     <= b_fire && b_in_rect && a_in_rect && (b_addr == a_addr);
    end
    if (rect_wr_en) begin
      fwd_data <= b_sum;
    end
  end

  // Read-modify-write of the rectangle sum, forwarding the write in flight.
  assign b_oper     = b_hit ? fwd_data : (rect_valid[b_addr] ? rect_rd_data : '0);
  assign b_sum      = b_oper + fdmd_pkg::RSUM_W'(b_diff);
  assign rect_wr_en = b_fire && b_in_rect;

  // Read port shared by the pixel updates and the frame end scan.
  assign scan_issue   = scan_active && (scan_cnt < total);
  assign rect_rd_en   = (accept && a_in_rect) || scan_issue;
  assign rect_rd_addr = scan_active ? scan_cnt[RECT_AW-1:0] : a_addr;

  fdmd_ram #(
    .WIDTH (fdmd_pkg::RSUM_W),
    .DEPTH (MAX_RECTS)
  ) u_rect_ram (
    .clk     (clk),
    .wr_en   (rect_wr_en),
    .wr_addr (b_addr),
    .wr_data (b_sum),
    .rd_en   (rect_rd_en),
    .rd_addr (rect_rd_addr),
    .rd_data (rect_rd_data)
  );

  // Entries not written since the last frame end read as zero.
  always_ff @(posedge clk) begin
    if (rst || hist_step) begin
      rect_valid <= '0;
    end else if (rect_wr_en) begin
      rect_valid[b_addr] <= 1'b1;
    end
  end

  // Scan address counter and read pipeline.
  always_ff @(posedge clk) begin
    if (rst) begin
      pipe_valid <= 1'b0;
    end else begin
      pipe_valid <= scan_issue;
    end
  end

  always_ff @(posedge clk) begin
    if (state == fdmd_pkg::ST_WAIT
        || (state == fdmd_pkg::ST_MIN && state_next == fdmd_pkg::ST_FLAG)) begin
      scan_cnt <= '0;
    end else if (scan_issue) begin
      scan_cnt <= scan_cnt + TOT_W'(1);
    end
    pipe_idx <= scan_cnt[RECT_AW-1:0];
  end

  assign scan_data = rect_valid[pipe_idx] ? rect_rd_data : '0;

  // First pass finds the minimum sum, second pass flags sums above it.
  always_ff @(posedge clk) begin
    if (state == fdmd_pkg::ST_WAIT) begin
      min_val   <= min_init;
      flags_acc <= '0;
    end else if (pipe_valid) begin
      if (state == fdmd_pkg::ST_MIN && scan_data < min_val) begin
        min_val <= scan_data;
      end
      if (state == fdmd_pkg::ST_FLAG && scan_data > min_val) begin
        flags_acc[pipe_idx] <= 1'b1;
      end
    end
  end

  // Energy history ring; the entry at the current slot is the oldest one.
  fdmd_ram #(
    .WIDTH (fdmd_pkg::ENERGY_W),
    .DEPTH (fdmd_pkg::HIST_DEPTH)
  ) u_hist_ram (
    .clk     (clk),
    .wr_en   (emit_fire),
    .wr_addr (history_slot),
    .wr_data (energy_hold),
    .rd_en   (1'b1),
    .rd_addr (history_slot),
    .rd_data (hist_rd_data)
  );

  assign hist_old = hist_valid[history_slot] ? hist_rd_data : '0;
  assign sum_next = sum_run + fdmd_pkg::HIST_SUM_W'(energy_hold);

  // Running sum of the history: drop the oldest energy, then add the new one.
  always_ff @(posedge clk) begin
    if (rst) begin
      sum_run       <= '0;
      prior_average <= '0;
      history_slot  <= '0;
      hist_valid    <= '0;
    end else if (hist_step) begin
      sum_run <= sum_run - fdmd_pkg::HIST_SUM_W'(hist_old);
    end else if (emit_fire) begin
      sum_run                  <= sum_next;
      prior_average            <= sum_next[fdmd_pkg::HIST_SUM_W-1:fdmd_pkg::HIST_AW];
      history_slot             <= history_slot + fdmd_pkg::HIST_AW'(1);
      hist_valid[history_slot] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (hist_step) begin
      motion_hold <= energy_hold > prior_average;
    end
  end

  // Output register: pixel results and frame summaries.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((b_fire && !b_end) || emit_fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      diff_pixel     <= end_diff;
      frame_done     <= 1'b1;
      frame_energy   <= energy_hold;
      motion_flag    <= motion_hold;
      energy_average <= sum_next[fdmd_pkg::HIST_SUM_W-1:fdmd_pkg::HIST_AW];
      rect_flags     <= flags_acc;
    end else if (b_fire && !b_end) begin
      diff_pixel     <= b_diff;
      frame_done     <= 1'b0;
      frame_energy   <= '0;
      motion_flag    <= 1'b0;
      energy_average <= '0;
      rect_flags     <= '0;
    end
  end

`ifndef SYNTHESIS
  // No pixel enters while the last pixel of a frame is still in the update stage.
  assert property (@(posedge clk) disable iff (rst) (b_valid && b_end) |-> in_stall)
    else $error("pixel accepted behind the last pixel of a frame");

  // The rectangle memory is never written while it is being scanned.
  assert property (@(posedge clk) disable iff (rst) scan_active |-> !rect_wr_en)
    else $error("rectangle sum written during the frame end scan");

  // A frame summary that leaves the emit state shows up as a frame result.
  assert property (@(posedge clk) disable iff (rst)
    emit_fire |=> (out_valid && frame_done))
    else $error("frame summary not presented after emit");

  // The scan never covers more rectangles than the memory holds.
  assert property (@(posedge clk) disable iff (rst)
    (state == fdmd_pkg::ST_RUN) |-> (total <= TOT_W'(MAX_RECTS)))
    else $error("rectangle count beyond memory depth");
`endif

endmodule

### sim/frame_difference_motion_detector_unit_test.sv
// Self-checking testbench of the frame difference motion detector unit.
`timescale 1ns / 100ps

module frame_difference_motion_detector_unit_test;
  import fdmd_pkg::*;

  localparam int MAX_RECTS   = 64;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int HOLD_CYCLES = 150;

  // One pixel pair on the input channel.
  typedef struct packed {
    logic [PIX_W-1:0] cur;
    logic [PIX_W-1:0] base;
  } pixel_pair_t;

  // One result on the output channel.
  typedef struct packed {
    logic [PIX_W-1:0]    diff;
    logic                done;
    logic [ENERGY_W-1:0] energy;
    logic                motion;
    logic [ENERGY_W-1:0] average;
    logic [FLAGS_W-1:0]  flags;
  } pixel_result_t;

  // Kind of scene content generated for one frame.
  typedef enum int {
    ACT_STILL,
    ACT_NOISE,
    ACT_MOVING
  } activity_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DIM_W-1:0]     cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [PIX_W-1:0]     cur_pixel = '0;
  logic [PIX_W-1:0]     base_pixel = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [PIX_W-1:0]     diff_pixel;
  logic                 frame_done;
  logic [ENERGY_W-1:0]  frame_energy;
  logic                 motion_flag;
  logic [ENERGY_W-1:0]  energy_average;
  logic [FLAGS_W-1:0]   rect_flags;

  // Stimulus and scoreboard.
  pixel_pair_t   pending_pixels[$];
  pixel_result_t expected_results[$];
  pixel_pair_t   next_pixel;
  bit            pixel_taken = 1'b0;
  bit            send_hold = 1'b0;
  bit            hold_request = 1'b0;
  int unsigned   send_idle_pct = 0;
  int unsigned   recv_idle_pct = 0;
  int unsigned   send_gap_left = 0;
  int unsigned   recv_burst_left = 0;
  int unsigned   hold_left = 0;
  int unsigned   cycle_count = 0;
  int unsigned   error_count = 0;
  int unsigned   pixels_queued = 0;
  int unsigned   pixels_checked = 0;
  int unsigned   frames_checked = 0;
  int unsigned   motion_frames = 0;
  int unsigned   settings_used = 0;

  // Register copies kept by the predictor.
  logic [DIM_W-1:0] img_w = IMAGE_WIDTH_RST;
  logic [DIM_W-1:0] img_h = IMAGE_HEIGHT_RST;
  logic [DIM_W-1:0] blk_w = RECT_WIDTH_RST;
  logic [DIM_W-1:0] blk_h = RECT_HEIGHT_RST;
  logic [PIX_W-1:0] floor_lvl = DIFF_FLOOR_RST;

  // Raster position, sums and energy history kept by the predictor.
  logic [DIM_W-1:0]    col_pos = '0;
  logic [DIM_W-1:0]    row_pos = '0;
  logic [DIM_W-1:0]    rect_x_off = '0;
  logic [RCNT_W-1:0]   rect_x = '0;
  logic [DIM_W-1:0]    rect_y_off = '0;
  logic [RCNT_W-1:0]   rect_y = '0;
  logic [ENERGY_W-1:0] energy_sum = '0;
  logic [RSUM_W-1:0]   region_sum[MAX_RECTS] = '{default: '0};
  logic [ENERGY_W-1:0] energy_ring[HIST_DEPTH] = '{default: '0};
  logic [HIST_AW-1:0]  ring_ptr = '0;
  logic [ENERGY_W-1:0] avg_prev = '0;

  frame_difference_motion_detector_unit #(
    .MAX_RECTS(MAX_RECTS)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .cur_pixel(cur_pixel),
    .base_pixel(base_pixel),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .diff_pixel(diff_pixel),
    .frame_done(frame_done),
    .frame_energy(frame_energy),
    .motion_flag(motion_flag),
    .energy_average(energy_average),
    .rect_flags(rect_flags)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Advances the motion detector by one pixel and queues the result it must give.
  function automatic void predict_pixel(input logic [PIX_W-1:0] cur,
                                        input logic [PIX_W-1:0] base);
    logic [DIM_W-1:0]      w, h, rw, rh;
    int unsigned           across, down, total, idx, min_sum, i;
    logic [PIX_W-1:0]      d;
    logic                  row_end, frame_end;
    logic [HIST_SUM_W-1:0] ring_total;
    logic [FLAGS_W-1:0]    flags;
    pixel_result_t         r;
    w  = (img_w == 0) ? DIM_W'(1) : img_w;
    h  = (img_h == 0) ? DIM_W'(1) : img_h;
    rw = (blk_w == 0) ? DIM_W'(1) : blk_w;
    rh = (blk_h == 0) ? DIM_W'(1) : blk_h;
    across = w / rw;
    down = h / rh;
    total = across * down;
    if (total > MAX_RECTS) total = MAX_RECTS;
    d = (cur > base) ? cur - base : '0;

    // Energy and the sum of the whole rectangle holding this pixel.
    if (d > floor_lvl) energy_sum = energy_sum + ENERGY_W'(d) * ENERGY_W'(d);
    if (rect_x < across && rect_y < down) begin
      idx = rect_y * across + rect_x;
      if (idx < MAX_RECTS) region_sum[idx] = region_sum[idx] + RSUM_W'(d);
    end

    r = '0;
    r.diff = d;
    row_end = (col_pos + 1 >= w);
    frame_end = row_end && (row_pos + 1 >= h);

    if (frame_end) begin
      // Frame summary: rectangle flags against the smallest sum, then the history.
      min_sum = 255 * rw * rh;
      flags = '0;
      for (i = 0; i < total; i++)
        if (region_sum[i] < min_sum) min_sum = region_sum[i];
      for (i = 0; i < total; i++)
        if (region_sum[i] > min_sum) flags[i] = 1'b1;
      foreach (region_sum[k]) region_sum[k] = '0;
      r.done = 1'b1;
      r.energy = energy_sum;
      r.motion = (energy_sum > avg_prev);
      energy_ring[ring_ptr] = energy_sum;
      ring_ptr = ring_ptr + 1'b1;
      ring_total = '0;
      foreach (energy_ring[k]) ring_total = ring_total + energy_ring[k];
      avg_prev = ENERGY_W'(ring_total / HIST_DEPTH);
      r.average = avg_prev;
      r.flags = flags;
      energy_sum = '0;
      col_pos = '0;
      row_pos = '0;
      rect_x_off = '0;
      rect_x = '0;
      rect_y_off = '0;
      rect_y = '0;
    end else if (row_end) begin
      col_pos = '0;
      rect_x_off = '0;
      rect_x = '0;
      row_pos = row_pos + 1'b1;
      if (rect_y_off + 1 >= rh) begin
        rect_y_off = '0;
        if (rect_y < RCNT_MAX) rect_y = rect_y + 1'b1;
      end else begin
        rect_y_off = rect_y_off + 1'b1;
      end
    end else begin
      col_pos = col_pos + 1'b1;
      if (rect_x_off + 1 >= rw) begin
        rect_x_off = '0;
        if (rect_x < RCNT_MAX) rect_x = rect_x + 1'b1;
      end else begin
        rect_x_off = rect_x_off + 1'b1;
      end
    end
    expected_results = {expected_results, r};
  endfunction

  task automatic compare_field(input string label, input logic [63:0] want,
                               input logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, label, want, got);
      error_count++;
    end
  endtask

  // Sender: offers queued pixels at the falling edge, with random gaps.
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || pixel_taken) begin
      if (send_gap_left > 0) begin
        send_gap_left--;
        in_valid <= 1'b0;
      end else if (pending_pixels.size() != 0 && !send_hold) begin
        next_pixel = pending_pixels.pop_front();
        cur_pixel <= next_pixel.cur;
        base_pixel <= next_pixel.base;
        in_valid <= 1'b1;
        if ($urandom_range(99) < send_idle_pct) send_gap_left = $urandom_range(1, 6);
      end else begin
        in_valid <= 1'b0;
      end
    end
    pixel_taken = 1'b0;
  end

  // Receiver: stalls in random bursts, and for one long stretch on request.
  always @(negedge clk) begin
    if (hold_request) begin
      hold_left = HOLD_CYCLES;
      hold_request = 1'b0;
    end
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (recv_burst_left > 0) begin
      recv_burst_left--;
      out_stall <= 1'b1;
    end else if ($urandom_range(99) < recv_idle_pct) begin
      recv_burst_left = $urandom_range(1, 6) - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Monitor: checks each output transfer and predicts each input transfer.
  always @(posedge clk) begin
    pixel_result_t want;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result with no pixel outstanding, actual diff %0h done %0b",
                   $time, diff_pixel, frame_done);
          error_count++;
        end else begin
          want = expected_results.pop_front();
          compare_field("diff_pixel", want.diff, diff_pixel);
          compare_field("frame_done", want.done, frame_done);
          compare_field("frame_energy", want.energy, frame_energy);
          compare_field("motion_flag", want.motion, motion_flag);
          compare_field("energy_average", want.average, energy_average);
          compare_field("rect_flags", want.flags, rect_flags);
          pixels_checked++;
          if (want.done) frames_checked++;
          if (want.motion) motion_frames++;
        end
      end
      if (in_valid && !in_stall) begin
        predict_pixel(cur_pixel, base_pixel);
        pixel_taken = 1'b1;
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: run timed out with %0d results outstanding", $time,
               expected_results.size());
      $display("FAILURE");
      $finish;
    end
  end

  task automatic queue_pixel(input logic [PIX_W-1:0] cur, input logic [PIX_W-1:0] base);
    pixel_pair_t p;
    p.cur = cur;
    p.base = base;
    pending_pixels = {pending_pixels, p};
    pixels_queued++;
  endtask

  // Queues pixels of one kind of scene: still, noisy or moving.
  task automatic queue_scene(input int unsigned count);
    activity_t act;
    int unsigned k, b, c;
    act = activity_t'($urandom_range(0, 2));
    for (k = 0; k < count; k++) begin
      b = $urandom_range(0, 255);
      case (act)
        ACT_STILL: begin
          c = $urandom_range(0, b);
        end
        ACT_NOISE: begin
          c = $urandom_range(0, 255);
        end
        default: begin
          c = b + $urandom_range(0, 255 - b);
        end
      endcase
      queue_pixel(PIX_W'(c), PIX_W'(b));
    end
  endtask

  // Returns once nothing is queued, offered or outstanding.
  task automatic wait_idle();
    while (pending_pixels.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [DIM_W-1:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    case (idx)
      REG_IMAGE_WIDTH:  img_w = value;
      REG_IMAGE_HEIGHT: img_h = value;
      REG_RECT_WIDTH:   blk_w = value;
      REG_RECT_HEIGHT:  blk_h = value;
      REG_DIFF_FLOOR:   floor_lvl = value[PIX_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Changes the whole setting once the block has gone quiet.
  task automatic set_geometry(input int unsigned w, input int unsigned h,
                              input int unsigned rw, input int unsigned rh,
                              input int unsigned fl);
    wait_idle();
    write_register(REG_IMAGE_WIDTH, DIM_W'(w));
    write_register(REG_IMAGE_HEIGHT, DIM_W'(h));
    write_register(REG_RECT_WIDTH, DIM_W'(rw));
    write_register(REG_RECT_HEIGHT, DIM_W'(rh));
    write_register(REG_DIFF_FLOOR, DIM_W'(fl));
    settings_used++;
  endtask

  initial begin
    int unsigned phase, sel, w, h, rw, rh, fl, frames, f, area, start_count;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: field extremes and the floor boundary at the reset geometry.
    send_idle_pct = 20;
    recv_idle_pct = 20;
    queue_pixel(8'hFF, 8'h00);
    queue_pixel(8'h00, 8'hFF);
    queue_pixel(8'h00, 8'h00);
    queue_pixel(8'hFF, 8'hFF);
    queue_pixel(8'd41, 8'd0);
    queue_pixel(8'd40, 8'd0);
    queue_pixel(8'h80, 8'h7F);
    queue_pixel(8'hAA, 8'h55);
    queue_pixel(8'h55, 8'hAA);

    // Geometry shrunk mid-frame: the column counter is past the new width.
    set_geometry(4, 2, 2, 1, 0);
    queue_pixel(8'd200, 8'd10);
    queue_pixel(8'd10, 8'd200);
    queue_pixel(8'd90, 8'd30);
    queue_pixel(8'd255, 8'd254);
    queue_pixel(8'd17, 8'd3);

    // Zero dimensions act as one: every pixel ends a frame; top floor blocks energy.
    set_geometry(0, 0, 0, 0, 255);
    queue_pixel(8'd200, 8'd10);
    queue_pixel(8'd10, 8'd200);
    queue_pixel(8'd255, 8'd0);

    // Rectangle wider than the image: no whole rectangle, no flags.
    set_geometry(3, 2, 4, 1, 0);
    queue_pixel(8'd99, 8'd1);
    queue_pixel(8'd1, 8'd99);
    queue_pixel(8'd255, 8'd0);
    queue_pixel(8'd128, 8'd0);
    queue_pixel(8'd0, 8'd0);
    queue_pixel(8'd77, 8'd33);

    // Largest register values, left mid-frame for the next setting.
    set_geometry(4095, 4095, 4095, 4095, 255);
    queue_scene(20);
    set_geometry(4095, 4095, 1, 1, 0);
    queue_scene(20);

    // Random settings, each followed by whole frames and often a partial one.
    phase = 0;
    while (pixels_queued < 1100) begin
      sel = $urandom_range(0, 11);
      if (sel == 0) begin
        // One long row: rectangle columns reach or run past the counter ceiling.
        w = $urandom_range(128, 140);
        h = 1;
        rw = 1;
        rh = 1;
        frames = 1;
      end else if (sel == 1) begin
        // Dense grid: from 54 to 96 rectangles, often more than the block keeps.
        w = $urandom_range(9, 12);
        h = $urandom_range(6, 8);
        rw = $urandom_range(0, 1);
        rh = $urandom_range(0, 1);
        frames = $urandom_range(1, 2);
      end else if (sel == 2) begin
        w = $urandom_range(0, 3);
        h = $urandom_range(0, 3);
        rw = $urandom_range(0, 2);
        rh = $urandom_range(0, 2);
        frames = $urandom_range(4, 10);
      end else begin
        w = $urandom_range(1, 8);
        h = $urandom_range(1, 4);
        rw = $urandom_range(1, w + 2);
        rh = $urandom_range(1, h + 1);
        frames = $urandom_range(3, 8);
      end
      case ($urandom_range(0, 3))
        0: fl = 0;
        1: fl = 255;
        default: fl = $urandom_range(0, 80);
      endcase
      case ($urandom_range(0, 2))
        0: send_idle_pct = 0;
        1: send_idle_pct = 15;
        default: send_idle_pct = 40;
      endcase
      case ($urandom_range(0, 2))
        0: recv_idle_pct = 0;
        1: recv_idle_pct = 15;
        default: recv_idle_pct = 40;
      endcase
      set_geometry(w, h, rw, rh, fl);
      area = ((w == 0) ? 1 : w) * ((h == 0) ? 1 : h);
      start_count = pixels_queued;
      for (f = 0; f < frames; f++) queue_scene(area);
      if (area > 1 && $urandom_range(0, 2) == 0) queue_scene($urandom_range(1, area - 1));

      // Long output hold-off while pixels keep coming.
      if (phase == 3) hold_request = 1'b1;

      // Sender pause until every outstanding result has arrived.
      if (phase == 5) begin
        while (pending_pixels.size() > (pixels_queued - start_count) / 2) @(posedge clk);
        send_hold = 1'b1;
        while (in_valid || expected_results.size() != 0) @(posedge clk);
        send_hold = 1'b0;
      end
      phase++;
    end

    // Closing frames at full rate on both sides.
    set_geometry(6, 4, 2, 2, 20);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_scene(24);
    queue_scene(24);

    wait_idle();
    repeat (40) @(posedge clk);
    $display("Checked %0d pixel results in %0d frames, %0d of them flagged as motion,",
             pixels_checked, frames_checked, motion_frames);
    $display("over %0d register settings with random and long stalls on both channels.",
             settings_used);
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### frame_difference_motion_detector_unit.f
rtl/core/fdmd_pkg.sv
rtl/core/fdmd_ram.sv
rtl/core/fdmd_div.sv
rtl/core/fdmd_raster.sv
rtl/core/frame_difference_motion_detector_unit.sv
sim/frame_difference_motion_detector_unit_test.sv
